/* design/lir_pkg.sv */
`timescale 1ns / 1ps

package lir_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int STEP_W            = 21;
  localparam int SAMPLE_W          = 16;

  // result limits per input item
  localparam int INTERP_MAX = 16;
  localparam int TOTAL_MAX  = 32;
  localparam int CNT_W      = $clog2(TOTAL_MAX + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_INTERP = 3'b010,
    ST_HOLD   = 3'b100
  } state_t;

  typedef struct packed {
    logic load;          // latch the accepted item
    logic prev_from_in;  // first sample of a sound: store it straight away
    logic emit;          // issue one result into the blend pipeline
    logic hold_mode;     // result repeats the current sample
    logic run_last;
    logic sound_done;
    logic sub_one;       // position moves on to the next input interval
    logic save_prev;     // current sample becomes the previous one
    logic clear;         // end of sound: position and previous sample to zero
  } cmd_t;

  typedef struct packed {
    logic pos_lt_one;    // position < 1.0
    logic nxt_lt_one;    // position + step < 1.0
    logic nxt2_lt_one;   // position + step - 1.0 < 1.0
    logic issue_ok;      // blend pipeline can take a result
  } status_t;

endpackage

/* design/lir_ctrl.sv */
`timescale 1ns / 1ps

module lir_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stream_end,
  output logic             in_ready,
  input  lir_pkg::status_t status,
  output lir_pkg::cmd_t    cmd
);

  lir_pkg::state_t state_r, state_nxt;
  logic [lir_pkg::CNT_W-1:0] n_r, n_nxt;
  logic have_r, have_nxt;
  logic last_r, last_nxt;
  logic more;

  localparam logic [lir_pkg::CNT_W-1:0] N_INTERP = lir_pkg::CNT_W'(lir_pkg::INTERP_MAX);
  localparam logic [lir_pkg::CNT_W-1:0] N_TOTAL  = lir_pkg::CNT_W'(lir_pkg::TOTAL_MAX);
  localparam logic [lir_pkg::CNT_W-1:0] N_ONE    = lir_pkg::CNT_W'(1);

  assign in_ready = (state_r == lir_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    have_nxt  = have_r;
    last_nxt  = last_r;
    more      = 1'b0;
    cmd       = '0;
    unique case (state_r)
      lir_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          n_nxt    = '0;
          last_nxt = in_stream_end;
          if (have_r) begin
            state_nxt = lir_pkg::ST_INTERP;
          end else if (in_stream_end) begin
            state_nxt = lir_pkg::ST_HOLD;
          end else begin
            cmd.prev_from_in = 1'b1;
            have_nxt         = 1'b1;
          end
        end
      end
      lir_pkg::ST_INTERP: begin
        if (status.pos_lt_one && (n_r < N_INTERP)) begin
          if (status.issue_ok) begin
            // another result follows either in this interval or in the final hold run
            more = (status.nxt_lt_one && (n_r < N_INTERP - N_ONE)) ||
                   (last_r && status.nxt2_lt_one && (n_r < N_TOTAL - N_ONE));
            cmd.emit       = 1'b1;
            cmd.run_last   = !more;
            cmd.sound_done = last_r && !more;
            n_nxt          = n_r + N_ONE;
          end
        end else begin
          cmd.sub_one = 1'b1;
          if (last_r) begin
            state_nxt = lir_pkg::ST_HOLD;
          end else begin
            cmd.save_prev = 1'b1;
            have_nxt      = 1'b1;
            state_nxt     = lir_pkg::ST_IDLE;
          end
        end
      end
      lir_pkg::ST_HOLD: begin
        if (status.pos_lt_one && (n_r < N_TOTAL)) begin
          if (status.issue_ok) begin
            more           = status.nxt_lt_one && (n_r < N_TOTAL - N_ONE);
            cmd.emit       = 1'b1;
            cmd.hold_mode  = 1'b1;
            cmd.run_last   = !more;
            cmd.sound_done = !more;
            n_nxt          = n_r + N_ONE;
          end
        end else begin
          cmd.clear = 1'b1;
          have_nxt  = 1'b0;
          state_nxt = lir_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lir_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lir_pkg::ST_IDLE;
      n_r     <= '0;
      have_r  <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      have_r  <= have_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

/* design/lir_datapath.sv */
`timescale 1ns / 1ps

module lir_datapath #(
  parameter int FRACTION_BITS = lir_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lir_pkg::STEP_W-1:0]        cfg_wdata,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] in_sample_in,
  input  lir_pkg::cmd_t                     cmd,
  output lir_pkg::status_t                  status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lir_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                              out_run_last,
  output logic                              out_sound_done
);

  localparam int SW    = lir_pkg::SAMPLE_W;
  localparam int FB    = FRACTION_BITS;
  localparam int POS_W = FB + 8;
  localparam int CW    = ((POS_W > lir_pkg::STEP_W) ? POS_W : lir_pkg::STEP_W) + 1;
  localparam int PW    = FB + SW + 2;

  localparam logic [CW-1:0] ONE_C    = CW'(1) << FB;
  localparam logic [CW-1:0] STEP_MIN = ONE_C >> 4;
  localparam logic [CW-1:0] STEP_MAX = ONE_C << 4;
  localparam logic [lir_pkg::STEP_W-1:0] STEP_RST = ONE_C[lir_pkg::STEP_W-1:0];
  localparam logic [POS_W-1:0] ONE_P = ONE_C[POS_W-1:0];

  logic [lir_pkg::STEP_W-1:0] step_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic signed [SW-1:0] prev_r, prev_nxt;
  logic signed [SW-1:0] cur_r;

  logic [CW-1:0]    step_ext, step_cl;
  logic [POS_W-1:0] step_c, pos_add, pos_sub, pos_add_sub;

  // blend pipeline: product stage, then output register
  logic                 p1_valid_r;
  logic signed [SW-1:0] p1_s0_r;
  logic signed [PW-1:0] p1_prod_r;
  logic                 p1_run_last_r, p1_done_r;
  logic                 out_valid_r, out_run_last_r, out_done_r;
  logic signed [SW-1:0] out_sample_r;

  logic                 adv2;
  logic signed [SW-1:0] s0;
  logic signed [SW:0]   diff;
  logic signed [PW-1:0] prod, acc;
  logic [FB-1:0]        frac;
  logic                 round_up;
  logic [SW-1:0]        blend_val;

  always_comb begin
    step_ext = CW'(step_r);
    if (step_ext < STEP_MIN) begin
      step_cl = STEP_MIN;
    end else if (step_ext > STEP_MAX) begin
      step_cl = STEP_MAX;
    end else begin
      step_cl = step_ext;
    end
    step_c = step_cl[POS_W-1:0];
  end

  assign pos_add     = pos_r + step_c;
  assign pos_sub     = pos_r - ONE_P;
  assign pos_add_sub = pos_add - ONE_P;

  assign adv2 = !out_valid_r || out_ready;

  always_comb begin
    status.pos_lt_one  = ~|pos_r[POS_W-1:FB];
    status.nxt_lt_one  = ~|pos_add[POS_W-1:FB];
    status.nxt2_lt_one = ~|pos_add_sub[POS_W-1:FB];
    status.issue_ok    = !p1_valid_r || adv2;
  end

  always_comb begin
    pos_nxt  = pos_r;
    prev_nxt = prev_r;
    if (cmd.prev_from_in) begin
      prev_nxt = in_sample_in;
    end
    if (cmd.emit) begin
      pos_nxt = pos_add;
    end
    if (cmd.sub_one) begin
      pos_nxt = pos_sub;
    end
    if (cmd.save_prev) begin
      prev_nxt = cur_r;
    end
    if (cmd.clear) begin
      pos_nxt  = '0;
      prev_nxt = '0;
    end
  end

  // s0*(1-t) + s1*t computed as s0*1 + (s1-s0)*t
  always_comb begin
    frac = pos_r[FB-1:0];
    if (cmd.hold_mode) begin
      s0   = cur_r;
      diff = '0;
    end else begin
      s0   = prev_r;
      diff = {cur_r[SW-1], cur_r} - {prev_r[SW-1], prev_r};
    end
    prod = $signed({{(PW-SW-1){diff[SW]}}, diff}) * $signed({{(PW-FB){1'b0}}, frac});
  end

  // truncate toward zero: negative sums with a nonzero fraction round up
  always_comb begin
    acc       = $signed({{(PW-SW-FB){p1_s0_r[SW-1]}}, p1_s0_r, {FB{1'b0}}}) + p1_prod_r;
    round_up  = acc[PW-1] && (|acc[FB-1:0]);
    blend_val = acc[FB+SW-1:FB] + SW'(round_up);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_RST;
      pos_r       <= '0;
      prev_r      <= '0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        step_r <= cfg_wdata;
      end
      pos_r  <= pos_nxt;
      prev_r <= prev_nxt;
      if (cmd.emit) begin
        p1_valid_r <= 1'b1;
      end else if (adv2) begin
        p1_valid_r <= 1'b0;
      end
      if (adv2) begin
        out_valid_r <= p1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r <= in_sample_in;
    end
    if (cmd.emit) begin
      p1_s0_r       <= s0;
      p1_prod_r     <= prod;
      p1_run_last_r <= cmd.run_last;
      p1_done_r     <= cmd.sound_done;
    end
    if (adv2 && p1_valid_r) begin
      out_sample_r   <= blend_val;
      out_run_last_r <= p1_run_last_r;
      out_done_r     <= p1_done_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_run_last   = out_run_last_r;
  assign out_sound_done = out_done_r;

endmodule

/* design/linear_interp_resampler.sv */
`timescale 1ns / 1ps

// Linear-interpolation sample-rate converter for a mono 16-bit stream. Set
// cfg_wdata to input rate over output rate in fixed point (FRACTION_BITS
// fraction bits; the step is clamped to 1/16..16). Each input item yields the
// outputs whose positions fall in the interval ending at it, flagged with
// out_run_last on the last of them and out_sound_done on the final output of
// a sound (in_stream_end set). With no output stall, the first item of a
// sound is only stored unless it also ends the sound; any other item holds
// the input through its accept, the issue of its results one a cycle and
// the step that closes the interval or ends the sound; a final item that
// follows earlier items of its sound also closes its interval before its
// hold run. The controller issues one result a cycle into a two-stage
// multiply and round pipeline, and out_ready backpressure stalls issue once
// both stages are full. Write the step only while the block is idle.
module linear_interp_resampler #(
  parameter int FRACTION_BITS = lir_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lir_pkg::STEP_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                in_stream_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lir_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                out_run_last,
  output logic                                out_sound_done
);

  lir_pkg::cmd_t    cmd;
  lir_pkg::status_t status;

  lir_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stream_end (in_stream_end),
    .in_ready      (in_ready),
    .status        (status),
    .cmd           (cmd)
  );

  lir_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_sample_in   (in_sample_in),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_run_last   (out_run_last),
    .out_sound_done (out_sound_done)
  );

endmodule
